/* rtl/bsp_pkg.sv */
// Shared types, constants and a helper function for the brush segment polygon block.
package bsp_pkg;

	localparam int COORD_BITS = 16;
	localparam int CW         = COORD_BITS;
	localparam int XW         = CW + 1;
	localparam int YW         = CW + 2;
	localparam int SCROLL_W   = 16;
	localparam int YCW        = (YW > SCROLL_W + 1) ? YW : SCROLL_W + 1;
	localparam int WIDTH_W    = 8;
	localparam int OFF_W      = WIDTH_W + 1;

	// delta magnitude and the 2a-b terms of the sector test
	localparam int AW     = CW + 1;
	localparam int TW     = CW + 2;
	localparam int SQA_W  = 2 * AW;
	localparam int SQT_W  = 2 * TW;

	localparam int IN_DATA_W  = ((2 * CW + WIDTH_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((XW + YW + 7) / 8) * 8;

	localparam int NUM_SECT  = 12;
	localparam int SECT_W    = 4;
	localparam int NUM_VERT  = 14;
	localparam int HALF_VERT = 7;
	localparam int IDX_W     = 4;

	// v = floor(w * 1732 / 2000) as (w * V_RECIP) >> V_SHIFT
	localparam int V_SHIFT = 20;
	localparam logic [V_SHIFT-1:0] V_RECIP = V_SHIFT'((1732 * (2 ** V_SHIFT) + 1999) / 2000);

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	localparam logic [1:0] MAG_ZERO = 2'd0;
	localparam logic [1:0] MAG_U    = 2'd1;
	localparam logic [1:0] MAG_V    = 2'd2;
	localparam logic [1:0] MAG_W    = 2'd3;

	typedef struct packed {
		logic       neg;
		logic [1:0] mag;
	} code_t;

	localparam code_t OC_Z  = '{neg: 1'b0, mag: MAG_ZERO};
	localparam code_t OC_PU = '{neg: 1'b0, mag: MAG_U};
	localparam code_t OC_PV = '{neg: 1'b0, mag: MAG_V};
	localparam code_t OC_PW = '{neg: 1'b0, mag: MAG_W};
	localparam code_t OC_NU = '{neg: 1'b1, mag: MAG_U};
	localparam code_t OC_NV = '{neg: 1'b1, mag: MAG_V};
	localparam code_t OC_NW = '{neg: 1'b1, mag: MAG_W};

	localparam code_t OFF_X [NUM_SECT] = '{OC_Z, OC_NU, OC_NV, OC_NW, OC_NV, OC_NU,
	                                       OC_Z, OC_PU, OC_PV, OC_PW, OC_PV, OC_PU};
	localparam code_t OFF_Y [NUM_SECT] = '{OC_PW, OC_PV, OC_PU, OC_Z, OC_NU, OC_NV,
	                                       OC_NW, OC_NV, OC_NU, OC_Z, OC_PU, OC_PV};

	// one sample segment as handed from the front to the back
	typedef struct packed {
		logic signed [CW-1:0] px;
		logic signed [CW-1:0] py;
		logic [WIDTH_W-1:0]   pu;
		logic [WIDTH_W-1:0]   pv;
		logic [WIDTH_W-1:0]   pw;
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic [WIDTH_W-1:0]   cu;
		logic [WIDTH_W-1:0]   cv;
		logic [WIDTH_W-1:0]   cw;
		logic                 start;
		logic [SECT_W-1:0]    sect;
	} seg_t;

	function automatic logic signed [OFF_W-1:0] pick_off(code_t c, logic [WIDTH_W-1:0] u,
	                                                    logic [WIDTH_W-1:0] v,
	                                                    logic [WIDTH_W-1:0] w);
		logic [WIDTH_W-1:0] m;
		case (c.mag)
			MAG_ZERO: m = '0;
			MAG_U:    m = u;
			MAG_V:    m = v;
			default:  m = w;
		endcase
		pick_off = c.neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
	endfunction

endpackage

/* rtl/bsp_front.sv */
// Front part: accepts pen samples, keeps the previous point and finds the segment sector.
module bsp_front import bsp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [IN_DATA_W-1:0] in_data,
	input  logic                 in_start,
	output logic                 push,
	output seg_t                 push_data,
	input  logic                 q_full
);

	logic en;
	logic accept;
	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [CW-1:0]    pos_x, pos_y;
	logic [WIDTH_W-1:0]      bw;
	logic signed [CW-1:0]    prev_x_q, prev_y_q;
	logic [WIDTH_W-1:0]      prev_w_q;

	// stage 1
	logic signed [CW-1:0]    cx_s1, cy_s1, px_s1, py_s1;
	logic [WIDTH_W-1:0]      cbw_s1, pbw_s1;
	logic                    start_s1;
	logic signed [CW:0]      dx_s1, dy_s1;

	// stage 2 combinational
	logic [AW-1:0]           ax, ay;
	logic signed [TW:0]      t1, t2;
	logic                    dx_pos, dy_pos;
	quad_t                   quad;
	logic [WIDTH_W-1:0]      pw_c, cw_c;

	// stage 2
	seg_t                    seg_s2;
	logic [AW-1:0]           ax_s2;
	logic [TW-1:0]           t1m_s2, t2m_s2;
	logic                    t1le0_s2, t2ge0_s2, gt_s2, ge_s2, zero_s2;
	quad_t                   quad_s2;

	// stage 3
	seg_t                    seg_v;
	seg_t                    seg_s3;
	logic [SQA_W-1:0]        a2_s3;
	logic [SQT_W-1:0]        t1sq_s3, t2sq_s3;
	logic                    t1le0_s3, t2ge0_s3, gt_s3, ge_s3, zero_s3;
	quad_t                   quad_s3;
	logic [WIDTH_W+V_SHIFT-1:0] pv_prod, cv_prod;

	// stage 4
	logic [SQT_W-1:0]        a3;
	logic                    c1, c2, c3;
	logic [1:0]              q;
	logic [SECT_W-1:0]       sect;
	seg_t                    seg_d;
	seg_t                    seg_s4;

	assign pos_x  = in_data[CW-1:0];
	assign pos_y  = in_data[2*CW-1:CW];
	assign bw     = in_data[2*CW+WIDTH_W-1:2*CW];

	// hold the whole pipe while the last stage cannot enter the queue
	assign en       = !(v_s4 && q_full);
	assign in_ready = en;
	assign accept   = in_valid && en;
	assign push     = v_s4 && !q_full;
	assign push_data = seg_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_w_q <= '0;
		end else if (en) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (accept) begin
				prev_x_q <= pos_x;
				prev_y_q <= pos_y;
				prev_w_q <= bw;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1    <= pos_x;
			cy_s1    <= pos_y;
			cbw_s1   <= bw;
			start_s1 <= in_start;
			px_s1    <= prev_x_q;
			py_s1    <= prev_y_q;
			pbw_s1   <= prev_w_q;
			dx_s1    <= (CW+1)'(pos_x) - (CW+1)'(prev_x_q);
			dy_s1    <= (CW+1)'(pos_y) - (CW+1)'(prev_y_q);
		end
	end

	always_comb begin
		ax     = AW'(dx_s1[CW] ? -dx_s1 : dx_s1);
		ay     = AW'(dy_s1[CW] ? -dy_s1 : dy_s1);
		t1     = $signed({1'b0, ax, 1'b0}) - $signed({2'b00, ay});
		t2     = $signed({2'b00, ay}) - $signed({1'b0, ax, 1'b0});
		dx_pos = !dx_s1[CW] && (dx_s1 != '0);
		dy_pos = !dy_s1[CW] && (dy_s1 != '0);
		if (dx_pos && !dy_s1[CW])
			quad = QUAD_0;
		else if (!dx_pos && dy_pos)
			quad = QUAD_1;
		else if (dx_s1[CW] && !dy_pos)
			quad = QUAD_2;
		else
			quad = QUAD_3;
		pw_c = (pbw_s1 == '0) ? WIDTH_W'(1) : pbw_s1;
		cw_c = (cbw_s1 == '0) ? WIDTH_W'(1) : cbw_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s2.px    <= px_s1;
			seg_s2.py    <= py_s1;
			seg_s2.pw    <= pw_c;
			seg_s2.pu    <= (pw_c[WIDTH_W-1:1] == '0) ? WIDTH_W'(1) : WIDTH_W'(pw_c >> 1);
			seg_s2.pv    <= '0;
			seg_s2.cx    <= cx_s1;
			seg_s2.cy    <= cy_s1;
			seg_s2.cw    <= cw_c;
			seg_s2.cu    <= (cw_c[WIDTH_W-1:1] == '0) ? WIDTH_W'(1) : WIDTH_W'(cw_c >> 1);
			seg_s2.cv    <= '0;
			seg_s2.start <= start_s1;
			seg_s2.sect  <= '0;
			ax_s2        <= ax;
			t1m_s2       <= t1[TW-1:0];
			t2m_s2       <= t2[TW-1:0];
			t1le0_s2     <= t1[TW] || (t1 == '0);
			t2ge0_s2     <= !t2[TW];
			gt_s2        <= ay > ax;
			ge_s2        <= ay >= ax;
			zero_s2      <= (dx_s1 == '0) && (dy_s1 == '0);
			quad_s2      <= quad;
		end
	end

	assign pv_prod = seg_s2.pw * V_RECIP;
	assign cv_prod = seg_s2.cw * V_RECIP;

	always_comb begin
		seg_v    = seg_s2;
		seg_v.pv = pv_prod[WIDTH_W+V_SHIFT-1:V_SHIFT];
		seg_v.cv = cv_prod[WIDTH_W+V_SHIFT-1:V_SHIFT];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s3    <= seg_v;
			a2_s3     <= ax_s2 * ax_s2;
			t1sq_s3   <= t1m_s2 * t1m_s2;
			t2sq_s3   <= t2m_s2 * t2m_s2;
			t1le0_s3  <= t1le0_s2;
			t2ge0_s3  <= t2ge0_s2;
			gt_s3     <= gt_s2;
			ge_s3     <= ge_s2;
			zero_s3   <= zero_s2;
			quad_s3   <= quad_s2;
		end
	end

	// boundaries at 15, 45 and 75 degrees within the quadrant
	always_comb begin
		a3 = SQT_W'(a2_s3) + SQT_W'({a2_s3, 1'b0});
		c1 = t1le0_s3 || (a3 >= t1sq_s3);
		c2 = (quad_s3 == QUAD_1 || quad_s3 == QUAD_3) ? gt_s3 : ge_s3;
		c3 = t2ge0_s3 && (a3 <= t2sq_s3);
		if (c3)
			q = 2'd3;
		else if (c2)
			q = 2'd2;
		else if (c1)
			q = 2'd1;
		else
			q = 2'd0;
		if (zero_s3) begin
			sect = '0;
		end else begin
			case (quad_s3)
				QUAD_0:  sect = SECT_W'(q);
				QUAD_1:  sect = SECT_W'(NUM_SECT / 2) - SECT_W'(q);
				QUAD_2:  sect = SECT_W'(NUM_SECT / 2) + SECT_W'(q);
				QUAD_3:  sect = (q == 2'd0) ? '0 : SECT_W'(NUM_SECT) - SECT_W'(q);
				default: sect = '0;
			endcase
		end
		seg_d      = seg_s3;
		seg_d.sect = sect;
	end

	always_ff @(posedge clk) begin
		if (en)
			seg_s4 <= seg_d;
	end

endmodule

/* rtl/bsp_queue.sv */
// Short segment queue between the front and the back.
module bsp_queue import bsp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  seg_t push_data,
	output logic full,
	output logic valid,
	output seg_t data,
	input  logic pop
);

	seg_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full  = count_q == (QPTR_W+1)'(QDEPTH);
	assign valid = count_q != '0;
	assign data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + (QPTR_W+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (QPTR_W+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

/* rtl/bsp_back.sv */
// Back part: walks the fourteen vertices of one segment into the output register.
module bsp_back import bsp_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  seg_t                         q_data,
	output logic                         q_pop,
	input  logic signed [SCROLL_W-1:0]   scroll,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [OUT_DATA_W-1:0]        out_data,
	output logic                         out_last
);

	seg_t                   ent_q;
	logic                   busy_q;
	logic [IDX_W-1:0]       idx_q;
	logic [SECT_W-1:0]      k_q;
	logic                   ov_q;
	logic                   olast_q;
	logic signed [XW-1:0]   ox_q;
	logic signed [YW-1:0]   oy_q;

	logic                   out_free, emit, done;
	logic                   use_prev;
	logic signed [CW-1:0]   bx, by;
	logic [WIDTH_W-1:0]     su, sv, sw;
	logic signed [OFF_W-1:0] offx, offy;
	logic signed [XW-1:0]   vx;
	logic signed [YCW-1:0]  vy;

	assign out_free = !ov_q || out_ready;
	assign emit     = busy_q && out_free;
	assign done     = emit && (idx_q == IDX_W'(NUM_VERT - 1));
	assign q_pop    = q_valid && (!busy_q || done);

	always_comb begin
		use_prev = !ent_q.start && (idx_q < IDX_W'(HALF_VERT));
		bx   = use_prev ? ent_q.px : ent_q.cx;
		by   = use_prev ? ent_q.py : ent_q.cy;
		su   = use_prev ? ent_q.pu : ent_q.cu;
		sv   = use_prev ? ent_q.pv : ent_q.cv;
		sw   = use_prev ? ent_q.pw : ent_q.cw;
		offx = pick_off(OFF_X[k_q], su, sv, sw);
		offy = pick_off(OFF_Y[k_q], su, sv, sw);
		// previous point takes the offsets added, current point subtracted
		vx   = XW'(bx) + (use_prev ? XW'(offx) : -XW'(offx));
		vy   = YCW'(by) + (use_prev ? YCW'(offy) : -YCW'(offy)) - YCW'(scroll);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			k_q    <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
				k_q    <= q_data.start ? '0 : q_data.sect;
			end else if (done) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + IDX_W'(1);
				// restart the offset walk for the current point
				if (!ent_q.start && idx_q == IDX_W'(HALF_VERT - 1))
					k_q <= ent_q.sect;
				else if (k_q == SECT_W'(NUM_SECT - 1))
					k_q <= '0;
				else
					k_q <= k_q + SECT_W'(1);
			end
			if (emit)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			ent_q <= q_data;
		if (emit) begin
			ox_q    <= vx;
			oy_q    <= vy[YW-1:0];
			olast_q <= idx_q == IDX_W'(NUM_VERT - 1);
		end
	end

	assign out_valid = ov_q;
	assign out_last  = olast_q;
	assign out_data  = OUT_DATA_W'({oy_q, ox_q});

endmodule

/* rtl/brush_segment_polygon.sv */
// Top level of the brush segment polygon generator: front, queue, back and scroll register.
//
//  channel   dir  handshake                       contents
//  s_axis    in   s_axis_tvalid / s_axis_tready   pen sample, stroke_start on tuser
//  m_axis    out  m_axis_tvalid / m_axis_tready   polygon vertex, last_vertex on tlast
//  cfg       in   cfg_we                          scroll_offset
//
// Each sample gives fourteen vertices, one per cycle while m_axis_tready is high; the
// vertex walk in the back part sets that rate. The first vertex passes the front pipeline,
// the queue and the back entry register. The front and back stall on their own through
// a four-entry queue. Reset clears the previous point, previous width and scroll to zero.
module brush_segment_polygon import bsp_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [SCROLL_W-1:0]         cfg_wdata,      // scroll_offset
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [IN_DATA_W-1:0]        s_axis_tdata,   // pos_x, pos_y, brush_width
	input  logic                        s_axis_tuser,   // stroke_start
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [OUT_DATA_W-1:0]       m_axis_tdata,   // vertex_x, vertex_y
	output logic                        m_axis_tlast
);

	logic signed [SCROLL_W-1:0] scroll_q;
	logic push, q_full, q_valid, q_pop;
	seg_t push_data, q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			scroll_q <= '0;
		else if (cfg_we)
			scroll_q <= cfg_wdata;
	end

	bsp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.in_start  (s_axis_tuser),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	bsp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.valid     (q_valid),
		.data      (q_data),
		.pop       (q_pop)
	);

	bsp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.scroll    (scroll_q),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

/* tb/sv/tb_brush_segment_polygon.sv */
// Self-checking testbench for the brush segment polygon generator.
module tb_brush_segment_polygon;
	import bsp_pkg::*;

	// offset step codes per sector: +-1 = u, +-2 = v, +-3 = w
	localparam int X_STEP [NUM_SECT] = '{0, -1, -2, -3, -2, -1, 0, 1, 2, 3, 2, 1};
	localparam int Y_STEP [NUM_SECT] = '{3, 2, 1, 0, -1, -2, -3, -2, -1, 0, 1, 2};

	typedef struct {
		logic signed [XW-1:0] vx;
		logic signed [YW-1:0] vy;
		logic                 last;
	} vertex_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_we        = 1'b0;
	logic [SCROLL_W-1:0]   cfg_wdata     = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // pos_x, pos_y, brush_width
	logic                  s_axis_tuser  = 1'b0; // stroke_start
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;        // vertex_x, vertex_y
	logic                  m_axis_tlast;

	// predictor state
	logic signed [CW-1:0]       pen_x = '0;
	logic signed [CW-1:0]       pen_y = '0;
	logic [WIDTH_W-1:0]         pen_w = '0;
	logic signed [SCROLL_W-1:0] scroll = '0;

	vertex_t vertex_q[$];
	int errors           = 0;
	int samples_sent     = 0;
	int vertices_checked = 0;
	int strokes_begun    = 0;
	int scroll_settings  = 1;
	int sink_hold        = 0;
	int sink_calm        = 0;

	brush_segment_polygon dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#15000000;
		$display("%0t: timeout, %0d vertices still outstanding", $time, vertex_q.size());
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// sector test inside one quadrant; boundaries at 15, 45 and 75 degrees
	function automatic int quad_of(longint ax, longint ay, bit strict45);
		int q;
		longint t;
		q = 0;
		t = 2 * ax - ay;
		if (t <= 0 || 3 * ax * ax >= t * t)
			q = 1;
		if (strict45 ? (ay > ax) : (ay >= ax))
			q = 2;
		t = ay - 2 * ax;
		if (t >= 0 && 3 * ax * ax <= t * t)
			q = 3;
		return q;
	endfunction

	function automatic int heading(longint dx, longint dy);
		longint ax;
		longint ay;
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		if (dx == 0 && dy == 0)
			return 0;
		if (dx > 0 && dy >= 0)
			return quad_of(ax, ay, 1'b0);
		if (dx <= 0 && dy > 0)
			return 6 - quad_of(ax, ay, 1'b1);
		if (dx < 0 && dy <= 0)
			return 6 + quad_of(ax, ay, 1'b0);
		// last half sector folds back to zero
		return (12 - quad_of(ax, ay, 1'b1)) % 12;
	endfunction

	function automatic longint step_len(int code, longint u, longint v, longint w);
		longint m;
		int a;
		a = code < 0 ? -code : code;
		m = (a == 3) ? w : (a == 2) ? v : (a == 1) ? u : longint'(0);
		return code < 0 ? -m : m;
	endfunction

	function automatic void push_vertex(int idx, longint x, longint y, longint width, int k,
	                                    int sgn);
		longint w;
		longint u;
		longint v;
		longint rx;
		longint ry;
		vertex_t e;
		w = (width == 0) ? longint'(1) : width;
		u = (w / 2 < 1) ? longint'(1) : w / 2;
		v = w * 1732 / 2000;
		rx = x + longint'(sgn) * step_len(X_STEP[k % NUM_SECT], u, v, w);
		ry = y + longint'(sgn) * step_len(Y_STEP[k % NUM_SECT], u, v, w) - longint'(scroll);
		e.vx = XW'(rx);
		e.vy = YW'(ry);
		e.last = (idx == NUM_VERT - 1);
		vertex_q.push_back(e);
	endfunction

	function automatic void outline_sample(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
	                                       logic [WIDTH_W-1:0] w, bit start);
		longint px;
		longint py;
		int d;
		px = longint'(pen_x);
		py = longint'(pen_y);
		if (start) begin
			for (int i = 0; i < NUM_VERT; i++)
				push_vertex(i, longint'(x), longint'(y), longint'(w), i, -1);
		end else begin
			d = heading(longint'(x) - px, longint'(y) - py);
			for (int i = 0; i < HALF_VERT; i++)
				push_vertex(i, px, py, longint'(pen_w), d + i, 1);
			for (int i = 0; i < HALF_VERT; i++)
				push_vertex(i + HALF_VERT, longint'(x), longint'(y), longint'(w), d + i, -1);
		end
		pen_x = x;
		pen_y = y;
		pen_w = w;
	endfunction

	task automatic send_sample(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
	                           input logic [WIDTH_W-1:0] w, input bit start,
	                           input bit steady = 1'b0);
		int gap;
		gap = steady ? 0 : idle_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata  <= IN_DATA_W'({w, y, x});
		s_axis_tuser  <= start;
		s_axis_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		outline_sample(x, y, w, start);
		samples_sent++;
		if (start)
			strokes_begun++;
	endtask

	// drop valid and let every outstanding vertex drain
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (vertex_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_scroll(input logic signed [SCROLL_W-1:0] value);
		wait_idle();
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		scroll = value;
		scroll_settings++;
	endtask

	// continuing samples straight out of reset use point (0,0) and width zero
	task automatic test_after_reset();
		send_sample(16'sd0, 16'sd0, 8'd0, 1'b0);
		send_sample(16'sd300, 16'sd40, 8'd1, 1'b0);
	endtask

	task automatic test_extremes();
		write_scroll(16'sh8000);
		send_sample(16'sh8000, 16'sh7fff, 8'd255, 1'b1);
		send_sample(16'sh7fff, 16'sh8000, 8'd0, 1'b0);
		write_scroll(16'sh7fff);
		send_sample(16'sh7fff, 16'sh7fff, 8'd255, 1'b1);
		send_sample(16'sh8000, 16'sh8000, 8'd2, 1'b0);
	endtask

	// walk one step in each sector, then the 45 degree ties and the last half sector
	task automatic test_headings();
		int dx [17] = '{100, 87, 50, 0, -50, -87, -100, -87, -50, 0, 50, 87,
		                40, -40, -40, 40, 100};
		int dy [17] = '{0, 50, 87, 100, 87, 50, 0, -50, -87, -100, -87, -50,
		                40, 40, -40, -40, -10};
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		write_scroll(16'sd123);
		x = 16'sd0;
		y = 16'sd0;
		send_sample(x, y, 8'd20, 1'b1);
		for (int i = 0; i < 17; i++) begin
			x = x + CW'(dx[i]);
			y = y + CW'(dy[i]);
			send_sample(x, y, WIDTH_W'(3 + 15 * i), 1'b0);
		end
	endtask

	function automatic logic signed [CW-1:0] random_coord();
		if ($urandom_range(0, 99) < 30)
			return CW'($urandom);
		return CW'(int'($urandom_range(0, 4000)) - 2000);
	endfunction

	function automatic logic [WIDTH_W-1:0] random_width();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 8'd0;
		if (r < 14)
			return 8'd1;
		if (r < 20)
			return 8'd255;
		return WIDTH_W'($urandom_range(0, 255));
	endfunction

	// strokes of small random moves, with stray jumps and early restarts as noise
	task automatic test_random_strokes(input int count);
		logic signed [SCROLL_W-1:0] scrolls [5];
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		int sent;
		int len;
		int r;
		int dx;
		int dy;
		bit steady;
		scrolls[0] = SCROLL_W'($urandom);
		scrolls[1] = 16'sh7fff;
		scrolls[2] = 16'sh8000;
		scrolls[3] = SCROLL_W'($urandom_range(0, 600)) - 16'sd300;
		scrolls[4] = 16'sd0;
		sent = 0;
		for (int phase = 0; phase < 5; phase++) begin
			write_scroll(scrolls[phase]);
			while (sent < count * (phase + 1) / 5) begin
				steady = ($urandom_range(0, 99) < 25);
				x = random_coord();
				y = random_coord();
				send_sample(x, y, random_width(), 1'b1, steady);
				sent++;
				len = $urandom_range(2, 15);
				for (int i = 0; i < len && sent < count * (phase + 1) / 5; i++) begin
					r = $urandom_range(0, 99);
					if (r < 10) begin
						x = CW'($urandom);
						y = CW'($urandom);
					end else begin
						dx = (r < 18) ? 0 : int'($urandom_range(0, 600)) - 300;
						dy = (r >= 18 && r < 24) ? 0 : int'($urandom_range(0, 600)) - 300;
						x = x + CW'(dx);
						y = y + CW'(dy);
					end
					send_sample(x, y, random_width(), (r >= 95), steady);
					sent++;
				end
			end
		end
	endtask

	// result side: random stalls with calm stretches now and then
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if (sink_calm > 0)
				sink_calm <= sink_calm - 1;
			else if ($urandom_range(0, 99) < 2)
				sink_calm <= $urandom_range(30, 200);
			else
				sink_hold <= idle_gap();
		end
	end

	always @(posedge clk) begin
		vertex_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (vertex_q.size() == 0) begin
				$display("%0t: unexpected vertex x=%0d y=%0d last=%0b", $time,
				         $signed(m_axis_tdata[XW-1:0]), $signed(m_axis_tdata[XW+YW-1:XW]),
				         m_axis_tlast);
				errors++;
			end else begin
				want = vertex_q.pop_front();
				vertices_checked++;
				if (m_axis_tdata[XW-1:0] !== want.vx) begin
					$display("%0t: vertex_x expected %0d got %0d", $time, want.vx,
					         $signed(m_axis_tdata[XW-1:0]));
					errors++;
				end
				if (m_axis_tdata[XW+YW-1:XW] !== want.vy) begin
					$display("%0t: vertex_y expected %0d got %0d", $time, want.vy,
					         $signed(m_axis_tdata[XW+YW-1:XW]));
					errors++;
				end
				if (m_axis_tlast !== want.last) begin
					$display("%0t: last_vertex expected %0b got %0b", $time, want.last,
					         m_axis_tlast);
					errors++;
				end
			end
		end
	end

	initial begin
		int guard;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_extremes();
		test_headings();
		test_random_strokes(196);

		s_axis_tvalid <= 1'b0;
		guard = 0;
		while (vertex_q.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		if (vertex_q.size() != 0) begin
			$display("%0t: %0d expected vertices never arrived", $time, vertex_q.size());
			errors++;
		end
		// hold a little longer to catch stray vertices
		repeat (40) @(posedge clk);

		$display("Sent %0d pen samples in %0d strokes under %0d scroll settings;",
		         samples_sent, strokes_begun, scroll_settings);
		$display("checked %0d polygon vertices across all twelve sectors and ties.",
		         vertices_checked);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* sim.f */
rtl/bsp_pkg.sv
rtl/bsp_front.sv
rtl/bsp_queue.sv
rtl/bsp_back.sv
rtl/brush_segment_polygon.sv
tb/sv/tb_brush_segment_polygon.sv
